FILE: design/lbc_pkg.sv
// Shared types and constants for the LRU block cache.
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

   localparam int KEY_W            = 12;
   localparam int HANDLE_W         = 32;
   localparam int ENTRY_W          = KEY_W + HANDLE_W;
   localparam int CSR_W            = 5;
   localparam int CAPACITY_DEFAULT = 16;

   localparam logic [CSR_W-1:0] ACTIVE_LINES_RESET = 5'd16;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_PUT    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_APPEND,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] handle;
   } result_type;

endpackage

`default_nettype wire

FILE: design/lbc_mem.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lbc_mem #(
   parameter int DEPTH = lbc_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire logic [lbc_pkg::ENTRY_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic      [lbc_pkg::ENTRY_W-1:0] rd_data
);
   import lbc_pkg::*;

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/lbc_ctrl.sv
// Sequencer: search walk, recency shift, append and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module lbc_ctrl #(
   parameter int CAPACITY = lbc_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [lbc_pkg::CSR_W-1:0]      active_lines,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_kind,
   input  wire logic [3:0]                     req_drum_id,
   input  wire logic [7:0]                     req_block_id,
   input  wire logic [lbc_pkg::HANDLE_W-1:0]   req_line_handle,
   output logic                                res_valid,
   output lbc_pkg::result_type                 res,
   input  wire logic                           res_free,
   output logic                                mem_we,
   output logic [$clog2(CAPACITY)-1:0]         mem_waddr,
   output logic [lbc_pkg::ENTRY_W-1:0]         mem_wdata,
   output logic                                mem_re,
   output logic [$clog2(CAPACITY)-1:0]         mem_raddr,
   input  wire logic [lbc_pkg::ENTRY_W-1:0]    mem_rdata
);
   import lbc_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int LW = (OW > CSR_W) ? OW : CSR_W;

   state_type           state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [HANDLE_W-1:0] kept_ff, kept_in;
   logic                found_ff, found_in;
   logic [OW-1:0]       occ_ff, occ_in;
   logic [OW-1:0]       idx_ff, idx_in;
   logic [OW-1:0]       off_ff, off_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;

   logic [LW-1:0]       active_ext;
   logic [LW-1:0]       lim_wide;
   logic [OW-1:0]       lim;
   logic                key_match;
   logic [OW-1:0]       src_dst;

   always_comb begin
      active_ext = LW'(active_lines);
      if (active_ext == '0) begin
         lim_wide = LW'(1);
      end else if (active_ext > LW'(CAPACITY)) begin
         lim_wide = LW'(CAPACITY);
      end else begin
         lim_wide = active_ext;
      end
      lim = OW'(lim_wide);
   end

   assign key_match = pend_ff && (mem_rdata[ENTRY_W-1:HANDLE_W] == key_ff);
   assign src_dst   = idx_ff - off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         pend_ff  <= pend_in;
      end
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      handle_ff  <= handle_in;
      kept_ff    <= kept_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
      off_ff     <= off_in;
      wr_addr_ff <= wr_addr_in;
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      key_in     = key_ff;
      handle_in  = handle_ff;
      kept_in    = kept_ff;
      found_in   = found_ff;
      occ_in     = occ_ff;
      idx_in     = idx_ff;
      off_in     = off_ff;
      pend_in    = pend_ff;
      wr_addr_in = wr_addr_ff;
      req_stall  = (state_ff != ST_IDLE);
      res_valid  = 1'b0;
      res.hit    = found_ff;
      res.handle = (found_ff && (kind_ff == KIND_LOOKUP)) ? kept_ff : '0;
      mem_we     = 1'b0;
      mem_waddr  = wr_addr_ff;
      mem_wdata  = mem_rdata;
      mem_re     = 1'b0;
      mem_raddr  = idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               key_in    = {req_drum_id, req_block_id};
               handle_in = req_line_handle;
               found_in  = 1'b0;
               idx_in    = '0;
               pend_in   = 1'b0;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (key_match) begin
               // entry idx-1 matched; later entries move down by one
               found_in = 1'b1;
               kept_in  = mem_rdata[HANDLE_W-1:0];
               off_in   = OW'(1);
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end else if (idx_ff >= occ_ff) begin
               found_in = 1'b0;
               pend_in  = 1'b0;
               if (kind_ff == KIND_PUT) begin
                  if (occ_ff >= lim) begin
                     // evict the oldest entries down to one free line
                     off_in   = occ_ff - lim + OW'(1);
                     idx_in   = occ_ff - lim + OW'(1);
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end else begin
                  state_in = ST_RESPOND;
               end
            end else begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               idx_in  = idx_ff + OW'(1);
            end
         end
         ST_SHIFT: begin
            mem_we = pend_ff;
            if (idx_ff < occ_ff) begin
               mem_re     = 1'b1;
               pend_in    = 1'b1;
               wr_addr_in = src_dst[AW-1:0];
               idx_in     = idx_ff + OW'(1);
            end else begin
               pend_in  = 1'b0;
               occ_in   = occ_ff - off_ff;
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = occ_ff[AW-1:0];
            mem_wdata = {key_ff, (found_ff && (kind_ff == KIND_LOOKUP)) ? kept_ff : handle_ff};
            occ_in    = occ_ff + OW'(1);
            state_in  = ST_RESPOND;
         end
         ST_RESPOND: begin
            res_valid = 1'b1;
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/lru_block_cache.sv
// Top level of the LRU block cache: config register, sequencer, store, result register.
// Fully associative cache of CAPACITY entries keyed by drum and block number.
// Request channel (req_*): valid/stall; a transfer is a lookup (kind 0) or a
//   put (kind 1). req_stall is high from the transfer until the item finishes.
// Response channel (rsp_*): valid/stall; one transfer per request with the
//   hit flag and, on a lookup hit, the stored handle (zero otherwise).
// csr_wr_en/csr_wr_data write active_lines; write only while idle.
// Sequence: a search reads one entry per cycle; a hit or an eviction then
//   shifts the younger entries down, one per cycle, through the store's
//   write and read ports, then the entry is appended and the result handed
//   off. A lookup miss goes straight from the search to the hand-off.
// Only one item is in work at a time. A finished result sits in the response
//   register; the next request can be taken and searched while it waits, and
//   that item holds in its hand-off step until the register is free.
// Reset (synchronous) empties the cache, clears the response valid flag and
//   sets active_lines to 16. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_block_cache #(
   parameter int CAPACITY = lbc_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [lbc_pkg::CSR_W-1:0]    csr_wr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_kind,
   input  wire logic [3:0]                   req_drum_id,
   input  wire logic [7:0]                   req_block_id,
   input  wire logic [lbc_pkg::HANDLE_W-1:0] req_line_handle,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_hit,
   output logic      [lbc_pkg::HANDLE_W-1:0] rsp_handle_out
);
   import lbc_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic [CSR_W-1:0]    active_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;

   logic                res_valid;
   result_type          res;
   logic                res_free;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;
   logic [ENTRY_W-1:0]  mem_rdata;

   assign res_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_handle_in = rsp_handle_ff;
      if (res_valid && res_free) begin
         rsp_valid_in  = 1'b1;
         rsp_hit_in    = res.hit;
         rsp_handle_in = res.handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_LINES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff    <= rsp_hit_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_handle_out = rsp_handle_ff;

   lbc_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .active_lines    (active_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_drum_id     (req_drum_id),
      .req_block_id    (req_block_id),
      .req_line_handle (req_line_handle),
      .res_valid       (res_valid),
      .res             (res),
      .res_free        (res_free),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_re          (mem_re),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata)
   );

   lbc_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for lru_block_cache: random and directed lookups/puts checked against a cache model.
`timescale 1ns / 1ps

module testbench;
   import lbc_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 145;

   typedef struct packed {
      logic                kind;
      logic [3:0]          drum;
      logic [7:0]          block;
      logic [HANDLE_W-1:0] handle;
   } request_type;

   typedef struct packed {
      logic [3:0]          drum;
      logic [7:0]          block;
      logic [HANDLE_W-1:0] handle;
   } line_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CSR_W-1:0]    csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = KIND_LOOKUP;
   logic [3:0]          req_drum_id = '0;
   logic [7:0]          req_block_id = '0;
   logic [HANDLE_W-1:0] req_line_handle = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_hit;
   logic [HANDLE_W-1:0] rsp_handle_out;

   request_type pending_requests[$];
   result_type  expected_responses[$];
   request_type current_req;

   line_type         lines[CAPACITY];
   int unsigned      line_count = 0;
   logic [CSR_W-1:0] active_lines_shadow = ACTIVE_LINES_RESET;

   bit          gaps_on = 1'b1;
   int unsigned send_hold = 0;
   int unsigned stall_hold = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   logic [3:0] pool_drum[32];
   logic [7:0] pool_block[32];
   int unsigned pool_size;

   lru_block_cache dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_drum_id     (req_drum_id),
      .req_block_id    (req_block_id),
      .req_line_handle (req_line_handle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_handle_out  (rsp_handle_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   function automatic int unsigned effective_lines(logic [CSR_W-1:0] v);
      if (v == 0) return 1;
      if (v > CAPACITY) return CAPACITY;
      return 32'(v);
   endfunction

   function automatic void drop_line(int unsigned pos);
      for (int unsigned i = pos; i + 1 < line_count; i++) lines[i] = lines[i + 1];
      line_count--;
   endfunction

   // Search in recency order; hits and puts move the key to most recent.
   function automatic result_type cache_access(request_type r);
      result_type  res;
      int          pos;
      line_type    kept;
      int unsigned lim;
      res.hit    = 1'b0;
      res.handle = '0;
      pos        = -1;
      for (int i = 0; i < int'(line_count); i++) begin
         if (pos < 0 && lines[i].drum == r.drum && lines[i].block == r.block) pos = i;
      end
      if (pos >= 0) begin
         kept = lines[pos];
         drop_line(pos);
         res.hit = 1'b1;
         if (r.kind == KIND_LOOKUP) res.handle = kept.handle;
         else kept.handle = r.handle;
         lines[line_count] = kept;
         line_count++;
      end else if (r.kind == KIND_PUT) begin
         lim = effective_lines(active_lines_shadow);
         while (line_count >= lim && line_count > 0) drop_line(0);
         lines[line_count] = '{drum: r.drum, block: r.block, handle: r.handle};
         line_count++;
      end
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(21, 120);
   endfunction

   function automatic void report_mismatch(string what, result_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected hit=%0b handle=%h, got hit=%0b handle=%h", $realtime,
                  what, want.hit, want.handle, rsp_hit, rsp_handle_out);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(cache_access(current_req));
            send_hold = pick_gap();
         end
         if (!req_valid || !req_stall) begin
            if (send_hold > 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               current_req = pending_requests.pop_front();
               req_kind        <= current_req.kind;
               req_drum_id     <= current_req.drum;
               req_block_id    <= current_req.block;
               req_line_handle <= current_req.handle;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected transfer", '0);
            end else if (rsp_hit !== expected_responses[0].hit ||
                         rsp_handle_out !== expected_responses[0].handle) begin
               report_mismatch("response mismatch", expected_responses.pop_front());
            end else begin
               void'(expected_responses.pop_front());
            end
         end
         if (stall_hold == 0 && gaps_on && $urandom_range(0, 3) == 0) stall_hold = pick_gap();
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void queue_request(logic kind, logic [3:0] drum, logic [7:0] block,
                                         logic [HANDLE_W-1:0] handle);
      pending_requests.push_back('{kind: kind, drum: drum, block: block, handle: handle});
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0);
   endtask

   task automatic write_active_lines(logic [CSR_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_lines_shadow = v;
   endtask

   initial begin
      logic [CSR_W-1:0] phase_lines[PHASES];
      int unsigned      lim;
      int unsigned      k;
      phase_lines = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd5, 5'd17, 5'd8, 5'd15, 5'd3,
                      5'd16, 5'd9};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty cache, key extremes, update of a present key, then fill past capacity
      queue_request(KIND_LOOKUP, 4'd3, 8'h5a, 32'hdeadbeef);
      queue_request(KIND_PUT, 4'd0, 8'd0, 32'h0);
      queue_request(KIND_PUT, 4'd15, 8'd255, 32'hffffffff);
      queue_request(KIND_LOOKUP, 4'd0, 8'd0, 32'ha5a5a5a5);
      queue_request(KIND_LOOKUP, 4'd15, 8'd255, 32'h0);
      queue_request(KIND_PUT, 4'd15, 8'd255, 32'h12345678);
      queue_request(KIND_LOOKUP, 4'd15, 8'd255, 32'h5a5a5a5a);
      for (int i = 1; i <= 14; i++)
         queue_request(KIND_PUT, 4'(i), 8'(i * 17), 32'(i * 32'h01010101));
      queue_request(KIND_PUT, 4'd9, 8'd9, 32'h99999999);
      queue_request(KIND_LOOKUP, 4'd0, 8'd0, 32'h0);
      wait_drained();

      // limit lowered below occupancy: old entries stay until the next new put
      write_active_lines(5'd2);
      queue_request(KIND_LOOKUP, 4'd15, 8'd255, 32'h0);
      queue_request(KIND_LOOKUP, 4'd3, 8'd51, 32'h0);
      queue_request(KIND_PUT, 4'd7, 8'd7, 32'h77777777);
      queue_request(KIND_LOOKUP, 4'd3, 8'd51, 32'h0);
      wait_drained();

      // zero acts as one line; a put of a present key never evicts
      write_active_lines(5'd0);
      queue_request(KIND_PUT, 4'd7, 8'd7, 32'h70707070);
      queue_request(KIND_LOOKUP, 4'd7, 8'd7, 32'h0);
      queue_request(KIND_PUT, 4'd1, 8'd2, 32'h00000012);
      queue_request(KIND_LOOKUP, 4'd7, 8'd7, 32'h0);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) phase_lines[p] = CSR_W'($urandom_range(0, 31));
         write_active_lines(phase_lines[p]);
         gaps_on = (p % 4 != 3);
         lim = effective_lines(phase_lines[p]);
         pool_size = lim + $urandom_range(0, 4);
         if (pool_size > 32) pool_size = 32;
         for (int i = 0; i < int'(pool_size); i++) begin
            pool_drum[i]  = 4'($urandom_range(0, 15));
            pool_block[i] = 8'($urandom_range(0, 255));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 88) begin
               k = $urandom_range(0, pool_size - 1);
               queue_request(1'($urandom_range(0, 1)), pool_drum[k], pool_block[k], $urandom);
            end else begin
               queue_request(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                             8'($urandom_range(0, 255)), $urandom);
            end
         end
         wait_drained();
      end

      gaps_on = 1'b1;
      repeat (2 * CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
